// File: hdl/assert_macros.svh
// Assertion macros shared by the readability grade RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rgrd_pkg.sv
// Shared types, constants and byte classifiers for the readability grade block.
`default_nettype none

package rgrd_pkg;

  // Default counter width.
  localparam int COUNT_BITS_DEF = 16;

  // Headroom above the counter width for the scaled grade terms.
  localparam int SCALE_HEADROOM = 13;

  // Coleman-Liau weights, scaled by one hundred.
  localparam int LETTER_WEIGHT   = 588;
  localparam int SENTENCE_WEIGHT = 2960;
  localparam int WORD_WEIGHT     = 1580;
  localparam int DIV_SCALE       = 100;

  // Grade output range.
  localparam int GRADE_BITS = 5;
  localparam logic [GRADE_BITS-1:0] GRADE_MAX = GRADE_BITS'(16);

  // Character codes.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
  localparam logic [7:0] CHAR_QUEST   = 8'h3F;
  localparam logic [7:0] CHAR_EXCLAIM = 8'h21;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SIGN,
    ST_DIVIDE,
    ST_EMIT
  } rgrd_state_e;

  // Handshake between the sequencer and the output register.
  typedef struct packed {
    logic ready;
    logic take;
  } rgrd_emit_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
           ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_ender(input logic [7:0] c);
    return (c == CHAR_PERIOD) || (c == CHAR_QUEST) || (c == CHAR_EXCLAIM);
  endfunction

endpackage

`default_nettype wire

// File: hdl/rgrd_counter.sv
// Byte classifier and saturating letter, whitespace and sentence counters.
`default_nettype none

module rgrd_counter #(
  parameter int COUNT_BITS = rgrd_pkg::COUNT_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic [7:0]            char_code_i,
  input  wire logic                  last_char_i,
  output logic      [COUNT_BITS-1:0] letters_next_o,
  output logic      [COUNT_BITS-1:0] spaces_next_o,
  output logic      [COUNT_BITS-1:0] sentences_next_o
);
  import rgrd_pkg::*;

  logic [COUNT_BITS-1:0] letter_q, letter_d;
  logic [COUNT_BITS-1:0] space_q, space_d;
  logic [COUNT_BITS-1:0] sentence_q, sentence_d;

  // Counts including the current byte, each held at its maximum.
  always_comb begin
    letters_next_o   = letter_q;
    spaces_next_o    = space_q;
    sentences_next_o = sentence_q;
    if (is_letter(char_code_i)) begin
      if (letter_q != '1) letters_next_o = letter_q + COUNT_BITS'(1);
    end else if (is_space(char_code_i)) begin
      if (space_q != '1) spaces_next_o = space_q + COUNT_BITS'(1);
    end else if (is_ender(char_code_i)) begin
      if (sentence_q != '1) sentences_next_o = sentence_q + COUNT_BITS'(1);
    end
  end

  // The final byte of a text hands its counts on and clears the tallies.
  always_comb begin
    letter_d   = letter_q;
    space_d    = space_q;
    sentence_d = sentence_q;
    if (accept_i) begin
      if (last_char_i) begin
        letter_d   = '0;
        space_d    = '0;
        sentence_d = '0;
      end else begin
        letter_d   = letters_next_o;
        space_d    = spaces_next_o;
        sentence_d = sentences_next_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_q   <= '0;
      space_q    <= '0;
      sentence_q <= '0;
    end else begin
      letter_q   <= letter_d;
      space_q    <= space_d;
      sentence_q <= sentence_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rgrd_subtract.sv
// Shared subtractor with a greater-or-equal flag from its borrow.
`default_nettype none

module rgrd_subtract #(
  parameter int WIDTH = rgrd_pkg::COUNT_BITS_DEF + rgrd_pkg::SCALE_HEADROOM
) (
  input  wire logic [WIDTH-1:0] a_i,
  input  wire logic [WIDTH-1:0] b_i,
  output logic      [WIDTH-1:0] diff_o,
  output logic                  ge_o
);
  import rgrd_pkg::*;

  logic [WIDTH:0] full;

  // One subtraction gives both the difference and the compare.
  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[WIDTH-1:0];
  assign ge_o   = ~full[WIDTH];

endmodule

`default_nettype wire

// File: hdl/rgrd_seq.sv
// Sequencer that scales the counts and divides by repeated subtraction.
`default_nettype none
`include "assert_macros.svh"

module rgrd_seq #(
  parameter int COUNT_BITS = rgrd_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            capture_i,
  input  wire logic [COUNT_BITS-1:0]           letters_i,
  input  wire logic [COUNT_BITS-1:0]           spaces_i,
  input  wire logic [COUNT_BITS-1:0]           sentences_i,
  input  wire logic                            take_i,
  output logic                                 busy_o,
  output rgrd_pkg::rgrd_emit_t                 emit_o,
  output logic [rgrd_pkg::GRADE_BITS-1:0]      grade_o,
  output logic [COUNT_BITS-1:0]                letters_o,
  output logic [COUNT_BITS:0]                  words_o,
  output logic [COUNT_BITS-1:0]                sentences_o
);
  import rgrd_pkg::*;

  localparam int WIDE = COUNT_BITS + SCALE_HEADROOM;

  rgrd_state_e state_q, state_d;

  logic [COUNT_BITS-1:0] l_q, l_d;
  logic [COUNT_BITS:0]   w_q, w_d;
  logic [COUNT_BITS-1:0] s_q, s_d;
  logic [WIDE-1:0]       pos_q, pos_d;
  logic [WIDE-1:0]       neg_q, neg_d;
  logic [WIDE-1:0]       div_q, div_d;
  logic [WIDE-1:0]       rem_q, rem_d;
  logic [GRADE_BITS-1:0] grade_q, grade_d;

  logic [WIDE-1:0] alu_a, alu_b, alu_diff;
  logic            alu_ge;

  // Operand select for the shared subtractor.
  assign alu_a = (state_q == ST_SIGN) ? pos_q : rem_q;
  assign alu_b = (state_q == ST_SIGN) ? neg_q : div_q;

  rgrd_subtract #(
    .WIDTH(WIDE)
  ) u_sub (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .diff_o(alu_diff),
    .ge_o  (alu_ge)
  );

  // Next state and datapath control.
  always_comb begin
    state_d = state_q;
    l_d     = l_q;
    w_d     = w_q;
    s_d     = s_q;
    pos_d   = pos_q;
    neg_d   = neg_q;
    div_d   = div_q;
    rem_d   = rem_q;
    grade_d = grade_q;
    emit_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (capture_i) begin
          l_d     = letters_i;
          s_d     = sentences_i;
          w_d     = {1'b0, spaces_i} + (COUNT_BITS + 1)'(1);
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        // Numerator terms and twice the divisor, all scaled by one hundred.
        pos_d   = WIDE'(l_q) * WIDE'(LETTER_WEIGHT);
        neg_d   = WIDE'(s_q) * WIDE'(SENTENCE_WEIGHT) + WIDE'(w_q) * WIDE'(WORD_WEIGHT);
        div_d   = WIDE'(w_q) * WIDE'(2 * DIV_SCALE);
        grade_d = '0;
        state_d = ST_SIGN;
      end
      ST_SIGN: begin
        // A negative grade stays zero; otherwise add half the divisor to round.
        if (alu_ge) begin
          rem_d   = {alu_diff[WIDE-2:0], 1'b0} + {1'b0, div_q[WIDE-1:1]};
          state_d = ST_DIVIDE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DIVIDE: begin
        // One quotient step per cycle, stopping at the top grade.
        if (alu_ge && (grade_q != GRADE_MAX)) begin
          rem_d   = alu_diff;
          grade_d = grade_q + GRADE_BITS'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        emit_o.ready = 1'b1;
        emit_o.take  = take_i;
        if (take_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk_i) begin
    l_q     <= l_d;
    w_q     <= w_d;
    s_q     <= s_d;
    pos_q   <= pos_d;
    neg_q   <= neg_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    grade_q <= grade_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign grade_o     = grade_q;
  assign letters_o   = l_q;
  assign words_o     = w_q;
  assign sentences_o = s_q;

  `ASSERT_NEXT(a_capture_scales, clk_i, rst_ni, (state_q == ST_IDLE) && capture_i, state_q == ST_SCALE, "final byte did not start the grade calculation")
  `ASSERT_IMPLY(a_grade_range, clk_i, rst_ni, state_q == ST_EMIT, grade_q <= GRADE_MAX, "grade beyond top class")
  `ASSERT_IMPLY(a_quotient_done, clk_i, rst_ni, (state_q == ST_EMIT) && ($past(state_q) == ST_DIVIDE) && (grade_q != GRADE_MAX), rem_q < div_q, "division stopped with remainder not below divisor")

endmodule

`default_nettype wire

// File: hdl/text_readability_grade.sv
// Top level of the Coleman-Liau readability grade block.
// Text arrives one byte per beat; letters, whitespace bytes and sentence enders are
// counted in saturating counters of COUNT_BITS bits, and words are one plus the
// whitespace count. A byte without the last flag yields no result. After the final
// byte the input is stalled until the result has been taken into the output
// register. The counts are first scaled, then a shared subtractor checks the sign
// and forms the rounded quotient one grade step per cycle, capped at 16. The grade
// and the three counts then appear as one result beat, held in an output register
// until taken, and the counters start fresh for the next text.
`default_nettype none

module text_readability_grade #(
  parameter int COUNT_BITS = rgrd_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [7:0]                      char_code_i,
  input  wire logic                            last_char_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [rgrd_pkg::GRADE_BITS-1:0]      grade_class_o,
  output logic [COUNT_BITS-1:0]                letters_seen_o,
  output logic [COUNT_BITS:0]                  words_seen_o,
  output logic [COUNT_BITS-1:0]                sentences_seen_o
);
  import rgrd_pkg::*;

  logic                  accept;
  logic                  busy;
  logic                  take;
  rgrd_emit_t            emit;
  logic [COUNT_BITS-1:0] letters_next, spaces_next, sentences_next;
  logic [GRADE_BITS-1:0] grade;
  logic [COUNT_BITS-1:0] letters, sentences;
  logic [COUNT_BITS:0]   words;

  logic                  out_valid_q, out_valid_d;
  logic [GRADE_BITS-1:0] grade_q;
  logic [COUNT_BITS-1:0] letters_q, sentences_q;
  logic [COUNT_BITS:0]   words_q;

  assign accept     = in_valid_i & ~busy;
  assign in_stall_o = busy;

  rgrd_counter #(
    .COUNT_BITS(COUNT_BITS)
  ) u_counter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .char_code_i     (char_code_i),
    .last_char_i     (last_char_i),
    .letters_next_o  (letters_next),
    .spaces_next_o   (spaces_next),
    .sentences_next_o(sentences_next)
  );

  rgrd_seq #(
    .COUNT_BITS(COUNT_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .capture_i  (accept & last_char_i),
    .letters_i  (letters_next),
    .spaces_i   (spaces_next),
    .sentences_i(sentences_next),
    .take_i     (take),
    .busy_o     (busy),
    .emit_o     (emit),
    .grade_o    (grade),
    .letters_o  (letters),
    .words_o    (words),
    .sentences_o(sentences)
  );

  // The output register takes a result when it is empty or being drained.
  assign take = emit.ready & (~out_valid_q | ~out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit.take) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded only when a beat is taken in.
  always_ff @(posedge clk_i) begin
    if (emit.take) begin
      grade_q     <= grade;
      letters_q   <= letters;
      words_q     <= words;
      sentences_q <= sentences;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign grade_class_o    = grade_q;
  assign letters_seen_o   = letters_q;
  assign words_seen_o     = words_q;
  assign sentences_seen_o = sentences_q;

endmodule

`default_nettype wire
